### rtl/lmr_pkg.sv
// ----------------------------------------------------------------------------
// lmr_pkg: shared types and constants of the LED matrix refresher
// Operation codes, register indexes, item structs and the command format
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lmr_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SHIFT_W     = 4;
    localparam int LEVEL_W     = 8;
    localparam int TICK_W      = 16;
    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 4;
    localparam int BIT_W       = 5;
    // wide enough for any LED index the pattern mapping produces
    localparam int IDX_W       = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LATCH_LOW  = 3'd5;

    localparam logic [SHIFT_W-1:0] BRIGHTNESS_RESET = 4'd0;
    localparam logic [TICK_W-1:0]  ONE_HIGH_RESET   = 16'd35;
    localparam logic [TICK_W-1:0]  ONE_LOW_RESET    = 16'd30;
    localparam logic [TICK_W-1:0]  ZERO_HIGH_RESET  = 16'd18;
    localparam logic [TICK_W-1:0]  ZERO_LOW_RESET   = 16'd40;
    localparam logic [TICK_W-1:0]  LATCH_LOW_RESET  = 16'd5000;

    localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] pattern_col;
        logic [COORD_W-1:0] pattern_row;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } in_item_t;

    typedef struct packed {
        logic pin_level;
        logic refreshing;
        logic rejected;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] latch_low;
    } timing_t;

    typedef struct packed {
        op_t                   op;
        logic [COLOR_W-1:0]    color;
        logic [3:0][IDX_W-1:0] led_addr;
        logic [3:0]            led_en;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic store_busy;
    } status_t;

endpackage

`default_nettype wire

### rtl/lmr_ram.sv
// ----------------------------------------------------------------------------
// lmr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/lmr_front.sv
// ----------------------------------------------------------------------------
// lmr_front: input decode and command queue
// Dims the pattern color, maps a pixel to its four LED indexes and queues
// the resulting command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_front #(
    parameter int PATTERN_SIDE = 16,
    parameter int LED_COUNT    = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lmr_pkg::in_item_t             in_item,
    input  logic [lmr_pkg::SHIFT_W-1:0]   brightness_shift,
    output logic                          q_valid,
    input  logic                          q_pop,
    output lmr_pkg::cmd_t                 q_entry
);

    import lmr_pkg::*;

    localparam int STRIDE = 4 * PATTERN_SIDE;

    function automatic logic [LEVEL_W-1:0] dim(input logic [LEVEL_W-1:0] level,
                                               input logic [SHIFT_W-1:0] shift);
        logic [LEVEL_W-1:0] result;
        result = '0;
        if (shift < SHIFT_W'(LEVEL_W))
        begin
            result = level >> shift;
        end
        return result;
    endfunction

    cmd_t                  cmd_in;
    logic                  in_range;
    logic [IDX_W-1:0]      row_base;
    logic [IDX_W-1:0]      col2;
    logic [3:0][IDX_W-1:0] idx;
    logic                  push;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        in_range = (int'(in_item.pattern_col) < PATTERN_SIDE)
                && (int'(in_item.pattern_row) < PATTERN_SIDE);
        row_base = IDX_W'(STRIDE) * IDX_W'(in_item.pattern_row);
        col2     = IDX_W'(in_item.pattern_col) << 1;
        idx[0]   = row_base + col2;
        idx[1]   = row_base + col2 + IDX_W'(1);
        idx[2]   = row_base + IDX_W'(STRIDE - 1) - col2;
        idx[3]   = row_base + IDX_W'(STRIDE - 2) - col2;

        cmd_in.op       = in_item.operation;
        cmd_in.color    = {dim(in_item.green_level, brightness_shift),
                           dim(in_item.red_level, brightness_shift),
                           dim(in_item.blue_level, brightness_shift)};
        cmd_in.led_addr = idx;
        for (int k = 0; k < 4; k++)
        begin
            // skip LEDs past the end of the strip
            cmd_in.led_en[k] = in_range && (in_item.operation == OP_WRITE)
                            && ({1'b0, idx[k]} < (IDX_W + 1)'(LED_COUNT));
        end
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

### rtl/lmr_back.sv
// ----------------------------------------------------------------------------
// lmr_back: command execution and refresh sequencer
// Writes and clears the frame store, runs the latch / high / low bit
// timing on tick items and registers one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_back #(
    parameter int LED_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  lmr_pkg::cmd_t                 q_entry,
    output logic                          q_pop,
    input  lmr_pkg::timing_t              timing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lmr_pkg::out_item_t            out_item,
    output logic                          ram_wr_en,
    output logic [$clog2(LED_COUNT)-1:0]  ram_wr_addr,
    output logic [lmr_pkg::COLOR_W-1:0]   ram_wr_data,
    output logic [$clog2(LED_COUNT)-1:0]  ram_rd_addr,
    input  logic [lmr_pkg::COLOR_W-1:0]   ram_rd_data,
    output lmr_pkg::status_t              status
);

    import lmr_pkg::*;

    localparam int ADDR_W = $clog2(LED_COUNT);
    localparam logic [ADDR_W-1:0] LAST_LED = ADDR_W'(LED_COUNT - 1);

    typedef enum logic [2:0] {
        S_EXEC  = 3'b001,
        S_WRITE = 3'b010,
        S_CLEAR = 3'b100
    } back_state_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LATCH = 4'b0010,
        PH_HIGH  = 4'b0100,
        PH_LOW   = 4'b1000
    } phase_t;

    back_state_t        state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [ADDR_W-1:0]  led_reg, led_next;
    logic               color_ok_reg, color_ok_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [1:0]         slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    cmd_t               cmd_reg, cmd_next;
    out_item_t          out_item_reg, out_item_next;

    logic               busy;
    logic               out_free;
    logic               bit_now;
    logic [TICK_W-1:0]  ticks_inc;
    logic [TICK_W-1:0]  limit;

    assign busy        = (phase_reg != PH_IDLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign bit_now     = ram_rd_data[LAST_BIT - bit_reg];
    assign ticks_inc   = ticks_reg + TICK_W'(1);
    assign ram_rd_addr = led_reg;
    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;

    assign status.busy       = busy;
    assign status.store_busy = (state_reg == S_WRITE) || (state_reg == S_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        bit_next       = bit_reg;
        led_next       = led_reg;
        color_ok_next  = 1'b1;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = clr_reg;
        ram_wr_data    = '0;
        q_pop          = 1'b0;
        limit          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_EXEC:
            begin
                // hold while the color of a new LED is still on its way from the store
                if (q_valid && out_free && (!busy || color_ok_reg))
                begin
                    q_pop                    = 1'b1;
                    out_valid_next           = 1'b1;
                    out_item_next.pin_level  = (phase_reg == PH_HIGH);
                    out_item_next.refreshing = busy;
                    out_item_next.rejected   = 1'b0;
                    if (q_entry.op == OP_TICK)
                    begin
                        if (busy)
                        begin
                            case (phase_reg)
                                PH_LATCH:
                                begin
                                    ticks_next = ticks_inc;
                                    if (ticks_inc >= timing.latch_low)
                                    begin
                                        phase_next = PH_HIGH;
                                        ticks_next = '0;
                                    end
                                end
                                PH_HIGH:
                                begin
                                    limit      = bit_now ? timing.one_high : timing.zero_high;
                                    ticks_next = ticks_inc;
                                    if (ticks_inc >= limit)
                                    begin
                                        phase_next = PH_LOW;
                                        ticks_next = '0;
                                    end
                                end
                                PH_LOW:
                                begin
                                    limit      = bit_now ? timing.one_low : timing.zero_low;
                                    ticks_next = ticks_inc;
                                    if (ticks_inc >= limit)
                                    begin
                                        ticks_next = '0;
                                        phase_next = PH_HIGH;
                                        if (bit_reg == LAST_BIT)
                                        begin
                                            bit_next = '0;
                                            if (led_reg == LAST_LED)
                                            begin
                                                led_next   = '0;
                                                phase_next = PH_IDLE;
                                            end
                                            else
                                            begin
                                                led_next      = led_reg + ADDR_W'(1);
                                                color_ok_next = 1'b0;
                                            end
                                        end
                                        else
                                        begin
                                            bit_next = bit_reg + BIT_W'(1);
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    else if (busy)
                    begin
                        out_item_next.rejected = 1'b1;
                    end
                    else
                    begin
                        case (q_entry.op)
                            OP_WRITE:
                            begin
                                cmd_next   = q_entry;
                                slot_next  = 2'd0;
                                state_next = S_WRITE;
                            end
                            OP_CLEAR:
                            begin
                                clr_next   = '0;
                                state_next = S_CLEAR;
                            end
                            OP_START:
                            begin
                                phase_next               = PH_LATCH;
                                ticks_next               = '0;
                                led_next                 = '0;
                                bit_next                 = '0;
                                color_ok_next            = 1'b0;
                                out_item_next.refreshing = 1'b1;
                                out_item_next.pin_level  = 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_WRITE:
            begin
                ram_wr_en   = cmd_reg.led_en[slot_reg];
                ram_wr_addr = cmd_reg.led_addr[slot_reg][ADDR_W-1:0];
                ram_wr_data = cmd_reg.color;
                slot_next   = slot_reg + 2'd1;
                if (slot_reg == 2'd3)
                begin
                    state_next = S_EXEC;
                end
            end
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_LED)
                begin
                    clr_next   = '0;
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= PH_IDLE;
            ticks_reg     <= '0;
            bit_reg       <= '0;
            led_reg       <= '0;
            color_ok_reg  <= 1'b0;
            clr_reg       <= '0;
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            bit_reg       <= bit_next;
            led_reg       <= led_next;
            color_ok_reg  <= color_ok_next;
            clr_reg       <= clr_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

### rtl/led_matrix_ws2812_refresher.sv
// ----------------------------------------------------------------------------
// led_matrix_ws2812_refresher: frame store and one-wire LED transmitter
// Pattern writes fill a store of LED colors; tick items step the serial
// bit timing of a refresh over the whole strip.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    in_item  (in_item_t)
//   out       output      out_valid / out_stall  out_item (out_item_t)
//   cfg       input       cfg_write              cfg_index, cfg_data
//
// Ticks and rejected items pass through the two-entry queue and the
// registered result stage, one result per cycle while the output is free and
// the back end waits on no store access. A pixel write makes four writes on
// the store's one write port; a clear writes the whole store, one entry per
// cycle. After reset the back end clears the store; the queue still takes
// two items meanwhile. A start and every move to a new LED hold the back end
// for the registered store read of the next color. A stalled output holds
// the back end; a full queue stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_ws2812_refresher #(
    parameter int LED_COUNT    = 1024,
    parameter int PATTERN_SIDE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lmr_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lmr_pkg::out_item_t                out_item,
    input  logic                              cfg_write,
    input  logic [lmr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import lmr_pkg::*;

    localparam int ADDR_W = $clog2(LED_COUNT);

    logic [SHIFT_W-1:0] brightness_reg, brightness_next;
    timing_t            timing_reg, timing_next;

    logic               q_valid;
    logic               q_pop;
    cmd_t               q_entry;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [COLOR_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [COLOR_W-1:0] ram_rd_data;
    status_t            status;

    always_comb
    begin
        brightness_next = brightness_reg;
        timing_next     = timing_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_next       = cfg_data[SHIFT_W-1:0];
                REG_ONE_HIGH:   timing_next.one_high  = cfg_data[TICK_W-1:0];
                REG_ONE_LOW:    timing_next.one_low   = cfg_data[TICK_W-1:0];
                REG_ZERO_HIGH:  timing_next.zero_high = cfg_data[TICK_W-1:0];
                REG_ZERO_LOW:   timing_next.zero_low  = cfg_data[TICK_W-1:0];
                REG_LATCH_LOW:  timing_next.latch_low = cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg       <= BRIGHTNESS_RESET;
            timing_reg.one_high  <= ONE_HIGH_RESET;
            timing_reg.one_low   <= ONE_LOW_RESET;
            timing_reg.zero_high <= ZERO_HIGH_RESET;
            timing_reg.zero_low  <= ZERO_LOW_RESET;
            timing_reg.latch_low <= LATCH_LOW_RESET;
        end
        else
        begin
            brightness_reg <= brightness_next;
            timing_reg     <= timing_next;
        end
    end

    lmr_front #(
        .PATTERN_SIDE (PATTERN_SIDE),
        .LED_COUNT    (LED_COUNT)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .brightness_shift (brightness_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_entry          (q_entry)
    );

    lmr_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .timing      (timing_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .status      (status)
    );

    lmr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (LED_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // the store must not change under a running refresh
    a_no_write_in_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !ram_wr_en)
        else $error("store written during refresh");

    a_write_only_in_store_ops: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> status.store_busy)
        else $error("store written outside write or clear");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_reject_only_when_refreshing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.rejected) |-> out_item.refreshing)
        else $error("rejected result outside a refresh");

endmodule

`default_nettype wire

### dv/tb_led_matrix_ws2812_refresher.sv
// ----------------------------------------------------------------------------
// tb_led_matrix_ws2812_refresher: self-checking bench for the LED refresher
// Builds frames with random pattern writes and clears under several
// brightness settings, then runs a refresh tick by tick through the latch
// and the first LEDs under several timing settings. Every item is mirrored
// in a line-level predictor and each result is compared with the oldest
// predicted one. Both sides idle at random, and the result side holds off
// once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_led_matrix_ws2812_refresher;
    timeunit 1ns;
    timeprecision 1ps;

    import lmr_pkg::*;

    localparam int LEDS = 1024;
    localparam int SIDE = 16;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER = 1000;
    localparam int unsigned REFRESH_TICKS = 300;
    localparam int unsigned FRAME_ITEMS = 280;

    // indexes past the last register, to be ignored by the block
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        LINE_IDLE  = 2'd0,
        LINE_LATCH = 2'd1,
        LINE_HIGH  = 2'd2,
        LINE_LOW   = 2'd3
    } line_phase_t;

    class led_line_scoreboard;
        logic [COLOR_W-1:0] led_colors [LEDS];
        int unsigned        led_pos;
        logic [BIT_W-1:0]   bit_pos;
        logic [TICK_W-1:0]  phase_count;
        line_phase_t        phase;
        logic [SHIFT_W-1:0] shift;
        logic [TICK_W-1:0]  one_hi, one_lo, zero_hi, zero_lo, latch_lo;
        out_item_t          line_levels_due [$];
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            foreach (led_colors[i]) led_colors[i] = '0;
            led_pos = 0;
            bit_pos = '0;
            phase_count = '0;
            phase = LINE_IDLE;
            shift = BRIGHTNESS_RESET;
            one_hi = ONE_HIGH_RESET;
            one_lo = ONE_LOW_RESET;
            zero_hi = ZERO_HIGH_RESET;
            zero_lo = ZERO_LOW_RESET;
            latch_lo = LATCH_LOW_RESET;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_BRIGHTNESS: shift = value[SHIFT_W-1:0];
                REG_ONE_HIGH:   one_hi = value;
                REG_ONE_LOW:    one_lo = value;
                REG_ZERO_HIGH:  zero_hi = value;
                REG_ZERO_LOW:   zero_lo = value;
                REG_LATCH_LOW:  latch_lo = value;
                default: ;
            endcase
        endfunction

        function logic [LEVEL_W-1:0] dim(logic [LEVEL_W-1:0] level);
            return (shift >= 8) ? '0 : level >> shift;
        endfunction

        function void store_led(int unsigned idx, logic [COLOR_W-1:0] color);
            if (idx < LEDS) led_colors[idx] = color;
        endfunction

        function bit refresh_active();
            return phase != LINE_IDLE;
        endfunction

        function int unsigned pending();
            return line_levels_due.size();
        endfunction

        // one tick of the serial line
        function void step_line();
            logic [TICK_W-1:0] limit;
            logic              one;
            phase_count = phase_count + 1'b1;
            one = led_colors[led_pos][COLOR_W-1 - bit_pos];
            case (phase)
                LINE_LATCH:
                    if (phase_count >= latch_lo)
                    begin
                        phase = LINE_HIGH;
                        phase_count = '0;
                    end
                LINE_HIGH:
                begin
                    limit = one ? one_hi : zero_hi;
                    if (phase_count >= limit)
                    begin
                        phase = LINE_LOW;
                        phase_count = '0;
                    end
                end
                LINE_LOW:
                begin
                    limit = one ? one_lo : zero_lo;
                    if (phase_count >= limit)
                    begin
                        phase_count = '0;
                        phase = LINE_HIGH;
                        if (bit_pos == LAST_BIT)
                        begin
                            bit_pos = '0;
                            if (led_pos == LEDS - 1)
                            begin
                                led_pos = 0;
                                phase = LINE_IDLE;
                            end
                            else
                            begin
                                led_pos++;
                            end
                        end
                        else
                        begin
                            bit_pos++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void accept_cmd(in_item_t cmd);
            out_item_t          res;
            logic [COLOR_W-1:0] color;
            int unsigned        base;
            int unsigned        col;
            res.pin_level = (phase == LINE_HIGH);
            res.refreshing = refresh_active();
            res.rejected = 1'b0;
            col = cmd.pattern_col;
            if (cmd.operation == OP_TICK)
            begin
                if (refresh_active()) step_line();
            end
            else if (refresh_active())
            begin
                res.rejected = 1'b1;
            end
            else
            begin
                case (cmd.operation)
                    OP_WRITE:
                        if (cmd.pattern_col < SIDE && cmd.pattern_row < SIDE)
                        begin
                            color = {dim(cmd.green_level), dim(cmd.red_level),
                                     dim(cmd.blue_level)};
                            base = 4 * SIDE * cmd.pattern_row;
                            store_led(base + 2 * col, color);
                            store_led(base + 2 * col + 1, color);
                            store_led(base + (4 * SIDE - 1) - 2 * col, color);
                            store_led(base + (4 * SIDE - 2) - 2 * col, color);
                        end
                    OP_CLEAR:
                        foreach (led_colors[i]) led_colors[i] = '0;
                    default:
                    begin
                        phase = LINE_LATCH;
                        phase_count = '0;
                        led_pos = 0;
                        bit_pos = '0;
                        res.refreshing = 1'b1;
                        res.pin_level = 1'b0;
                    end
                endcase
            end
            line_levels_due.push_back(res);
        endfunction

        function void check_line(out_item_t got);
            out_item_t want;
            results_seen++;
            if (line_levels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: none due, got pin=%b refreshing=%b rejected=%b",
                             results_seen, got.pin_level, got.refreshing, got.rejected);
                return;
            end
            want = line_levels_due.pop_front();
            if (got.pin_level !== want.pin_level || got.refreshing !== want.refreshing ||
                got.rejected !== want.rejected)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: pin=%b/%b refreshing=%b/%b rejected=%b/%b (exp/act)",
                             results_seen, want.pin_level, got.pin_level, want.refreshing,
                             got.refreshing, want.rejected, got.rejected);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    led_line_scoreboard book;
    bit                 steady = 1'b0;
    bit                 held_done = 1'b0;
    int unsigned        quiet_cycles = 0;

    led_matrix_ws2812_refresher #(
        .LED_COUNT    (LEDS),
        .PATTERN_SIDE (SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic in_item_t make_pixel(op_t op, int unsigned col, int unsigned row,
                                            int unsigned red, int unsigned green,
                                            int unsigned blue);
        in_item_t c;
        c.operation = op;
        c.pattern_col = COORD_W'(col);
        c.pattern_row = COORD_W'(row);
        c.red_level = LEVEL_W'(red);
        c.green_level = LEVEL_W'(green);
        c.blue_level = LEVEL_W'(blue);
        return c;
    endfunction

    function automatic in_item_t make_cmd(op_t op);
        return make_pixel(op, $urandom_range(15), $urandom_range(15), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
    endfunction

    task automatic push_cmd(input in_item_t cmd);
        while (!steady && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= cmd;
        do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
        book.accept_cmd(cmd);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        book.set_reg(idx, value);
    endtask

    // drain the block, let a pending clear finish, then reprogram
    task automatic program_regs(input logic [15:0] shift, one_hi, one_lo, zero_hi, zero_lo,
                                input logic [15:0] latch, input bit poke_spare);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (LEDS + 16) @(posedge clk);
        write_reg(REG_BRIGHTNESS, shift);
        write_reg(REG_ONE_HIGH, one_hi);
        write_reg(REG_ONE_LOW, one_lo);
        write_reg(REG_ZERO_HIGH, zero_hi);
        write_reg(REG_ZERO_LOW, zero_lo);
        write_reg(REG_LATCH_LOW, latch);
        if (poke_spare)
        begin
            write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(16'hFFFF)));
            write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(16'hFFFF)));
        end
        cfg_write <= 1'b0;
    endtask

    // tick the strip while it refreshes, mixing in items that get rejected
    task automatic run_refresh(input int unsigned tick_cap);
        int unsigned ticks;
        ticks = 0;
        while (book.refresh_active() && ticks < tick_cap)
        begin
            if ($urandom_range(99) < 3)
            begin
                push_cmd(make_cmd(op_t'($urandom_range(2))));
            end
            else
            begin
                push_cmd(make_cmd(OP_TICK));
                ticks++;
            end
        end
    endtask

    // fill the store with random pattern writes, a few clears and idle ticks
    task automatic play_frame(input int unsigned builds);
        int unsigned pick;
        repeat (builds)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                push_cmd(make_cmd(OP_CLEAR));
            else if (pick < 20)
                push_cmd(make_cmd(OP_TICK));
            else
                push_cmd(make_cmd(OP_WRITE));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            book.check_line(out_item);
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_done && book.results_seen >= HOLD_AFTER)
            begin
                held_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < 11);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        program_regs(16'd0, 16'd2, 16'd1, 16'd1, 16'd1, 16'd3, 1'b0);
        push_cmd(make_pixel(OP_TICK, 0, 0, 0, 0, 0));
        push_cmd(make_pixel(OP_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF));
        push_cmd(make_pixel(OP_WRITE, 15, 15, 8'h80, 8'h01, 8'hFF));
        push_cmd(make_pixel(OP_WRITE, 15, 0, 8'h55, 8'hAA, 8'h0F));
        push_cmd(make_pixel(OP_WRITE, 0, 15, 8'hAA, 8'h55, 8'hF0));
        push_cmd(make_pixel(OP_CLEAR, 15, 15, 8'hFF, 8'hFF, 8'hFF));
        push_cmd(make_pixel(OP_WRITE, 7, 8, 8'hFF, 8'h00, 8'h80));
        push_cmd(make_pixel(OP_WRITE, 0, 0, 8'h01, 8'h80, 8'h00));

        program_regs(16'd4, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
        play_frame(FRAME_ITEMS);

        // no idling on either side for this whole frame
        steady = 1'b1;
        program_regs(16'hFFF8, 16'd3, 16'd1, 16'd1, 16'd1, 16'd0, 1'b0);
        play_frame(FRAME_ITEMS);
        steady = 1'b0;

        program_regs(16'h000F, 16'd0, 16'd2, 16'd1, 16'd0, 16'd2, 1'b1);
        play_frame(FRAME_ITEMS);

        program_regs(16'd7, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
        play_frame(FRAME_ITEMS);

        // start the strip and walk it through the latch and the first LEDs
        program_regs(16'd0, 16'd2, 16'd1, 16'd1, 16'd1, 16'd3, 1'b0);
        push_cmd(make_pixel(OP_WRITE, 0, 0, 8'h01, 8'h80, 8'h00));
        push_cmd(make_pixel(OP_START, 0, 0, 0, 0, 0));
        repeat (3) push_cmd(make_pixel(OP_TICK, 15, 15, 8'hFF, 8'hFF, 8'hFF));
        // anything but a tick is turned away while the strip is busy
        push_cmd(make_pixel(OP_WRITE, 3, 3, 8'hFF, 8'hFF, 8'hFF));
        push_cmd(make_pixel(OP_CLEAR, 0, 0, 0, 0, 0));
        push_cmd(make_pixel(OP_START, 0, 0, 0, 0, 0));
        repeat (4) push_cmd(make_pixel(OP_TICK, 0, 0, 0, 0, 0));
        run_refresh(REFRESH_TICKS);

        // zero durations act as one tick
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        run_refresh(REFRESH_TICKS);

        // longest durations: the phase counter keeps climbing
        program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_refresh(REFRESH_TICKS);

        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (32) @(posedge clk);
        if (book.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/lmr_pkg.sv
rtl/lmr_ram.sv
rtl/lmr_front.sv
rtl/lmr_back.sv
rtl/led_matrix_ws2812_refresher.sv
dv/tb_led_matrix_ws2812_refresher.sv
